/* sv/tsm_pkg.sv */
// Package for trimmed_segment_mean: widths, request kinds, source codes, payload types.
// No dependencies.
package tsm_pkg;
   localparam int MaxEvents = 1024;
   localparam int MaxLevels = 8;
   localparam int EvAw = $clog2(MaxEvents);
   localparam int LvW = $clog2(MaxLevels);

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   localparam logic [1:0] SRC_OWN = 2'd0;
   localparam logic [1:0] SRC_LEVEL = 2'd1;
   localparam logic [1:0] SRC_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] level;
      logic [19:0] event_length;
      logic signed [15:0] sample;
      logic [9:0] event_index;
   } req_type;

   typedef struct packed {
      logic signed [15:0] amplitude;
      logic [1:0] source;
      logic [9:0] read_index;
   } rsp_type;

   // divider control between top and divider
   typedef struct packed {
      logic start;
      logic signed [55:0] dividend;
      logic [31:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic signed [15:0] quotient;
   } div_sts_type;
endpackage

/* sv/tsm_if.sv */
// Valid/ready channel interfaces for trimmed_segment_mean.
// Depends on tsm_pkg.
interface tsm_req_if;
   import tsm_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tsm_rsp_if;
   import tsm_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tsm_csr_if;
   logic valid;
   logic ready;
   logic [15:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* sv/trimmed_segment_mean.sv */
// Top level of trimmed_segment_mean: event memory, level totals, read sequencer.
// Depends on tsm_pkg, tsm_if, tsm_div.
//
// Usage:
// req carries headers (kind 0), trace samples (kind 1) and reads (kind 2).
// csr writes trim_samples (reset value 1) and is always ready.
// Headers and samples are taken one per cycle. A sample's trimmed sum is
// kept in a register and written to the event memory with each in-window
// sample; level totals live in eight registers updated in place.
// A read that divides passes through a memory read, the select step, the
// bit-serial divider and the load of the response register. While a read
// is in flight req is held off. One response waits in the output register;
// while rsp is stalled the block still takes headers and samples, and holds
// a new read until the register is free.
// Reset clears the event counter, offset, running sum and level totals;
// event memory content is undefined until an event's header is written.
// When neither the event nor its level holds samples, the response skips the
// divider and reports the empty source.
module trimmed_segment_mean (
   input logic clock,
   input logic reset,
   tsm_req_if.sink req,
   tsm_rsp_if.source rsp,
   tsm_csr_if.sink csr
);
   import tsm_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD = 3'd1;
   localparam logic [2:0] ST_SEL = 3'd2;
   localparam logic [2:0] ST_DIV = 3'd3;

   // event memories: {sum, count, level}
   logic [47:0] ev_sum_mem [MaxEvents];
   logic [19:0] ev_cnt_mem [MaxEvents];
   logic [LvW-1:0] ev_lv_mem [MaxEvents];
   logic [47:0] rd_sum_ff;
   logic [19:0] rd_cnt_ff;
   logic [LvW-1:0] rd_lv_ff;

   logic [55:0] lv_sum_ff [MaxLevels];
   logic [31:0] lv_cnt_ff [MaxLevels];

   logic [15:0] trim_ff;
   logic [EvAw:0] ev_ctr_ff;
   logic [19:0] off_ff;
   logic [47:0] run_ff;
   logic [19:0] cur_cnt_ff;
   logic [LvW-1:0] cur_lv_ff;
   logic [2:0] st_ff, st_in;
   logic [9:0] ri_ff;
   logic oor_ff;
   rsp_type out_ff;
   logic out_v_ff;

   div_cmd_type dcmd;
   div_sts_type dsts;

   logic acc, is_hdr, is_smp, is_rd, hdr_ok, in_win;
   logic [LvW-1:0] hlv, slv;
   logic [20:0] twice;
   logic [19:0] hcnt;
   logic [20:0] wend;
   logic [47:0] run_new;
   logic [EvAw-1:0] widx;
   logic [LvW-1:0] sel_lv;

   tsm_div u_div (.clock(clock), .reset(reset), .cmd(dcmd), .sts(dsts));

   assign csr.ready = 1'b1;
   // all requests wait for an idle sequencer; reads also wait for a free output register
   assign req.ready = (st_ff == ST_IDLE) &&
      !(req.data.kind == KIND_READ && out_v_ff && !rsp.ready);
   assign acc = req.valid && req.ready;
   assign is_hdr = acc && req.data.kind == KIND_HEADER;
   assign is_smp = acc && req.data.kind == KIND_SAMPLE;
   assign is_rd = acc && req.data.kind == KIND_READ;
   assign hdr_ok = ev_ctr_ff < (EvAw+1)'(MaxEvents);
   assign widx = ev_ctr_ff[EvAw-1:0] - EvAw'(1);

   // header: clamp level, trimmed length
   always_comb begin
      hlv = (int'(req.data.level) >= MaxLevels) ? LvW'(MaxLevels-1) : LvW'(req.data.level);
      twice = 21'({trim_ff, 1'b0});
      hcnt = ({1'b0, req.data.event_length} > twice) ?
         20'({1'b0, req.data.event_length} - twice) : 20'd0;
   end

   // sample window test
   always_comb begin
      wend = 21'(trim_ff) + 21'(cur_cnt_ff);
      in_win = (ev_ctr_ff != '0) && off_ff >= 20'(trim_ff) && 21'(off_ff) < wend;
      run_new = run_ff + 48'(req.data.sample);
      slv = cur_lv_ff;
   end

   // event memory write and read
   always_ff @(posedge clock) begin
      if (is_hdr && hdr_ok) begin
         ev_sum_mem[ev_ctr_ff[EvAw-1:0]] <= '0;
         ev_cnt_mem[ev_ctr_ff[EvAw-1:0]] <= hcnt;
         ev_lv_mem[ev_ctr_ff[EvAw-1:0]] <= hlv;
      end else if (is_smp && in_win) begin
         ev_sum_mem[widx] <= run_new;
      end
      if (is_rd) begin
         rd_sum_ff <= ev_sum_mem[req.data.event_index[EvAw-1:0]];
         rd_cnt_ff <= ev_cnt_mem[req.data.event_index[EvAw-1:0]];
         rd_lv_ff <= ev_lv_mem[req.data.event_index[EvAw-1:0]];
      end
   end

   // read sequencer
   always_comb begin
      st_in = st_ff;
      dcmd = '0;
      sel_lv = oor_ff ? '0 : rd_lv_ff;
      unique case (st_ff)
         ST_IDLE: if (is_rd) st_in = ST_RD;
         ST_RD: st_in = ST_SEL;
         ST_SEL: begin
            if (!oor_ff && rd_cnt_ff != '0) begin
               dcmd.start = 1'b1;
               dcmd.dividend = 56'($signed(rd_sum_ff));
               dcmd.divisor = 32'(rd_cnt_ff);
               st_in = ST_DIV;
            end else if (lv_cnt_ff[sel_lv] != '0) begin
               dcmd.start = 1'b1;
               dcmd.dividend = lv_sum_ff[sel_lv];
               dcmd.divisor = lv_cnt_ff[sel_lv];
               st_in = ST_DIV;
            end else begin
               st_in = ST_IDLE;
            end
         end
         ST_DIV: if (dsts.done) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_ff <= 16'd1;
         ev_ctr_ff <= '0;
         off_ff <= '0;
         run_ff <= '0;
         st_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         for (int i = 0; i < MaxLevels; i++) begin
            lv_sum_ff[i] <= '0;
            lv_cnt_ff[i] <= '0;
         end
      end else begin
         if (csr.valid) trim_ff <= csr.data;
         st_ff <= st_in;
         if (is_hdr) begin
            if (hdr_ok) begin
               ev_ctr_ff <= ev_ctr_ff + 1'b1;
               off_ff <= '0;
               run_ff <= '0;
               cur_cnt_ff <= hcnt;
               cur_lv_ff <= hlv;
            end else begin
               off_ff <= '1;
            end
         end
         if (is_smp && ev_ctr_ff != '0) begin
            if (in_win) begin
               run_ff <= run_new;
               lv_sum_ff[slv] <= lv_sum_ff[slv] + 56'(req.data.sample);
               lv_cnt_ff[slv] <= lv_cnt_ff[slv] + 32'd1;
            end
            if (off_ff != '1) off_ff <= off_ff + 20'd1;
         end
         if (is_rd) begin
            ri_ff <= req.data.event_index;
            oor_ff <= 11'(req.data.event_index) >= 11'(MaxEvents);
         end
         // output register
         if (st_ff == ST_SEL && st_in == ST_IDLE) begin
            out_v_ff <= 1'b1;
            out_ff <= '{amplitude: '0, source: SRC_EMPTY, read_index: ri_ff};
         end else if (st_ff == ST_DIV && dsts.done) begin
            out_v_ff <= 1'b1;
            out_ff.amplitude <= dsts.quotient;
            out_ff.read_index <= ri_ff;
         end else if (rsp.ready) begin
            out_v_ff <= 1'b0;
         end
         if (st_ff == ST_SEL && st_in == ST_DIV)
            out_ff.source <= (!oor_ff && rd_cnt_ff != '0) ? SRC_OWN : SRC_LEVEL;
      end
   end

   assign rsp.valid = out_v_ff;
   assign rsp.data = out_ff;
endmodule

/* sv/tsm_div.sv */
// Restoring signed divider, one quotient bit per cycle, saturates to 16 bits.
// Depends on tsm_pkg.
module tsm_div (
   input logic clock,
   input logic reset,
   input tsm_pkg::div_cmd_type cmd,
   output tsm_pkg::div_sts_type sts
);
   import tsm_pkg::*;

   logic [55:0] rem_ff, rem_in;
   logic [55:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [56:0] trial;
   logic [55:0] shifted;
   logic signed [56:0] sq;
   logic signed [15:0] sat;

   always_comb begin
      shifted = {rem_ff[54:0], quo_ff[55]};
      trial = {1'b0, shifted} - {25'd0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in = '0;
         quo_in = cmd.dividend[55] ? 56'(-cmd.dividend) : cmd.dividend;
         den_in = cmd.divisor;
         neg_in = cmd.dividend[55];
         cnt_in = 6'd56;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one bit and try subtract
         quo_in = {quo_ff[54:0], ~trial[56]};
         rem_in = trial[56] ? shifted : trial[55:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // apply sign then clamp
   always_comb begin
      sq = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (sq > 57'sd32767) sat = 16'sh7fff;
      else if (sq < -57'sd32768) sat = -16'sh8000;
      else sat = sq[15:0];
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.quotient = sat;
endmodule

/* sv/tsm_checker.sv */
// Port-level checker for trimmed_segment_mean, bound to the top level.
// Depends on tsm_pkg, tsm_if.
module tsm_port_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [1:0] req_kind,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_source,
   input logic signed [15:0] rsp_amplitude
);
   import tsm_pkg::*;

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   // empty level gives zero
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_source == SRC_EMPTY |-> rsp_amplitude == 16'sd0)
      else $error("empty not zero");
   // source code valid
   a_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_source != 2'd3) else $error("bad source");
   // a read gives no response the next cycle
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_READ && !rsp_valid |=> !rsp_valid)
      else $error("response too early");
endmodule

bind trimmed_segment_mean tsm_port_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_kind(req.data.kind),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_source(rsp.data.source), .rsp_amplitude(rsp.data.amplitude)
);
